// ----- rtl/iirl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list package
// Shared constants, command codes, state encoding, transaction types and cell
// control for the indexed insert/remove list.
// ----------------------------------------------------------------------------
package iirl_pkg;

  localparam int DEPTH       = 64;
  localparam int ENTRY_WIDTH = 32;
  localparam int KIND_W      = 3;
  localparam int POS_W       = 7;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int GROUP       = 8;
  localparam int NUM_GROUPS  = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND = 3'd0,
    K_INSERT = 3'd1,
    K_REMOVE = 3'd2,
    K_READ   = 3'd3,
    K_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_REDUCE
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [POS_W-1:0]       position;
    logic [ENTRY_WIDTH-1:0] entry_data;
  } cmd_t;

  typedef struct packed {
    logic [ENTRY_WIDTH-1:0] read_data;
    logic                   accepted;
    logic [CNT_W-1:0]       entry_count;
    logic                   is_empty;
  } res_t;

  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic                   rd;
    logic [IDX_W-1:0]       idx;
    logic [ENTRY_WIDTH-1:0] data;
  } cell_ctl_t;

endpackage

// ----- rtl/iirl_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list cell
// One list slot: takes new data, its left or right neighbour's entry, and
// presents its entry on a registered tap when addressed by a read.
// ----------------------------------------------------------------------------
module iirl_cell (
  input  logic                            clk,
  input  logic [iirl_pkg::IDX_W-1:0]      slot,
  input  iirl_pkg::cell_ctl_t             ctl,
  input  logic [iirl_pkg::ENTRY_WIDTH-1:0] left,
  input  logic [iirl_pkg::ENTRY_WIDTH-1:0] right,
  output logic [iirl_pkg::ENTRY_WIDTH-1:0] entry,
  output logic [iirl_pkg::ENTRY_WIDTH-1:0] tap
);
  import iirl_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (slot == ctl.idx) begin
        entry <= ctl.data;
      end else if (slot > ctl.idx) begin
        entry <= left;
      end
    end else if (ctl.rem && (slot >= ctl.idx)) begin
      entry <= right;
    end
  end

  always_ff @(posedge clk) begin
    tap <= (ctl.rd && (slot == ctl.idx)) ? entry : '0;
  end

endmodule

// ----- rtl/iirl_or_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list read tree
// Two-level OR reduction of the cell taps: registered group stage, then a
// final OR across the groups.
// ----------------------------------------------------------------------------
module iirl_or_tree (
  input  logic                             clk,
  input  logic                             load,
  input  logic [iirl_pkg::ENTRY_WIDTH-1:0] taps [iirl_pkg::DEPTH],
  output logic [iirl_pkg::ENTRY_WIDTH-1:0] result
);
  import iirl_pkg::*;

  logic [ENTRY_WIDTH-1:0] groups      [NUM_GROUPS];
  logic [ENTRY_WIDTH-1:0] groups_next [NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      groups_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          groups_next[g] = groups_next[g] | taps[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      groups <= groups_next;
    end
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      result = result | groups[g];
    end
  end

endmodule

// ----- rtl/indexed_insert_remove_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/remove list
// Ordered list of up to 64 entries held in a chain of cells, with append,
// insert, remove, read and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel: a command transaction (kind, position, entry_data) moves on
//   a clock edge with cmd_valid high and cmd_stall low.
//   res channel: one result transaction per command (read_data, accepted,
//   entry_count, is_empty), taken on an edge with res_valid high and
//   res_stall low.
//   Insert shifts every cell above the position and remove every cell at or above it, when the command is taken.
//   A read picks the addressed cell through a registered two-level OR tree
//   of eight groups of eight taps.
//   The result passes the tap, group and output registers in that order;
//   cmd_stall stays high from the take until the result is loaded into the
//   output register, so a new command waits for the previous one.
//   A new command is taken while an earlier result still waits in the
//   output register; if res_stall holds, the next result waits in the
//   tree and cmd_stall stays high until the output register frees.
//   Reset empties the list (count zero) and clears res_valid; entry
//   contents are left as they are.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  iirl_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output iirl_pkg::res_t res
);
  import iirl_pkg::*;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             ok;
  logic             ok_next;
  logic             take;
  logic             tree_load;
  logic             out_load;
  logic             not_full;
  cell_ctl_t        ctl;

  logic [ENTRY_WIDTH-1:0] entries [DEPTH];
  logic [ENTRY_WIDTH-1:0] taps    [DEPTH];
  logic [ENTRY_WIDTH-1:0] tree_data;

  assign take     = cmd_valid && !cmd_stall;
  assign not_full = (count != CNT_W'(DEPTH));

  always_comb begin
    ctl        = '0;
    ctl.data   = cmd.entry_data;
    ctl.idx    = cmd.position[IDX_W-1:0];
    ok_next    = 1'b0;
    count_next = count;
    case (cmd.kind)
      K_APPEND: begin
        ok_next    = not_full;
        ctl.ins    = take && not_full;
        ctl.idx    = count[IDX_W-1:0];
        count_next = not_full ? count + CNT_W'(1) : count;
      end
      K_INSERT: begin
        ok_next    = not_full && (cmd.position <= count);
        ctl.ins    = take && ok_next;
        count_next = ok_next ? count + CNT_W'(1) : count;
      end
      K_REMOVE: begin
        ok_next    = (cmd.position < count);
        ctl.rem    = take && ok_next;
        count_next = ok_next ? count - CNT_W'(1) : count;
      end
      K_READ: begin
        ok_next    = (cmd.position < count);
        ctl.rd     = take && ok_next;
      end
      K_CLEAR: begin
        ok_next    = 1'b1;
        count_next = '0;
      end
      default: begin
        ok_next    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ok <= ok_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left;
    logic [ENTRY_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = entries[i];
    end else begin : g_mid_r
      assign right = entries[i+1];
    end

    iirl_cell u_cell (
      .clk   (clk),
      .slot  (IDX_W'(i)),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .entry (entries[i]),
      .tap   (taps[i])
    );
  end

  iirl_or_tree u_tree (
    .clk    (clk),
    .load   (tree_load),
    .taps   (taps),
    .result (tree_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (!res_valid || !res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_stall = 1'b1;
    tree_load = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
      end
      ST_GATHER: begin
        tree_load = 1'b1;
      end
      ST_REDUCE: begin
        out_load = !res_valid || !res_stall;
      end
      default: begin
        cmd_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.read_data   <= tree_data;
      res.accepted    <= ok;
      res.entry_count <= count;
      res.is_empty    <= (count == '0);
    end
  end

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> cmd_stall)
    else $error("command taken while previous one still in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond list depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.is_empty == (res.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_load_one_shot: assert property (@(posedge clk) disable iff (rst)
    out_load |=> !tree_load && (state == ST_IDLE))
    else $error("result loaded without returning to idle");
`endif

endmodule
